FILE: design/ssp_pkg.sv
package ssp_pkg;

  localparam int unsigned NODE_BITS   = 10;
  localparam int unsigned MAX_NODES   = 1024;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned DIST_BITS   = 30;
  localparam int unsigned STORE_DEPTH = 8192;
  localparam int unsigned STORE_BITS  = 13;
  localparam int unsigned TOTAL_BITS  = 14;

  localparam logic [DIST_BITS-1:0] INF_DIST = 30'd1000000000;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [NODE_BITS-1:0]   from_node;
    logic [NODE_BITS-1:0]   to_node;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

endpackage

FILE: design/ssp_edge_ram.sv
module ssp_edge_ram import ssp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [STORE_BITS-1:0] waddr_i,
  input  edge_t                 wdata_i,
  input  logic [STORE_BITS-1:0] raddr_i,
  output edge_t                 rdata_o
);

  edge_t mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/single_source_shortest_path_core.sv
// Shortest distances from node 1 over a stored undirected graph.
// Add edge: both directions written, in S_IDLE then S_ADD2. Clear: done in S_IDLE.
// Query: busy in S_QRY, result strobed after it; the receiver cannot stall it.
// Run: S_INIT writes every node, S_SEL scans them with one node read per cycle,
// S_SELW marks the pick; S_ERD and S_ECHK check each stored entry, S_EUPD relaxes a match.
// Reset is asynchronous and active low; it clears the edge count, overflow and control.
module single_source_shortest_path_core import ssp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op_i,
  input  logic [NODE_BITS-1:0]   end_a_i,
  input  logic [NODE_BITS-1:0]   end_b_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [NODE_BITS-1:0]   cfg_data_i,
  output logic                   result_valid_o,
  output logic [NODE_BITS-1:0]   node_index_o,
  output logic [DIST_BITS-1:0]   distance_o,
  output logic                   overflow_o
);

  // Control states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD2 = 4'd1;
  localparam logic [3:0] S_QRY  = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_SEL  = 4'd4;
  localparam logic [3:0] S_SELW = 4'd5;
  localparam logic [3:0] S_ERD  = 4'd6;
  localparam logic [3:0] S_ECHK = 4'd7;
  localparam logic [3:0] S_EUPD = 4'd8;

  // One node memory word holds the visited mark and the best distance.
  typedef struct packed {
    logic                 vis;
    logic [DIST_BITS-1:0] path_len;
  } node_t;

  logic [3:0]            state_q, state_d;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic                  ovf_q, ovf_d;
  logic [NODE_BITS-1:0]  ncfg_q;
  logic [NODE_BITS-1:0]  n_q, n_d;
  logic [NODE_BITS-1:0]  idx_q, idx_d;
  logic [NODE_BITS-1:0]  chk_idx_q;
  logic                  sv_q, sv_d;
  logic [DIST_BITS-1:0]  best_q, best_d;
  logic [NODE_BITS-1:0]  pick_q, pick_d;
  logic [TOTAL_BITS-1:0] eidx_q, eidx_d;
  logic                  qok_q, qok_d;
  logic [NODE_BITS-1:0]  qa_q, qa_d;
  logic [NODE_BITS-1:0]  hold_a_q;
  logic [NODE_BITS-1:0]  hold_b_q;
  logic [WEIGHT_BITS-1:0] hold_w_q;
  logic                  res_v_q;
  logic [NODE_BITS-1:0]  res_idx_q;
  logic [DIST_BITS-1:0]  res_dist_q;

  // Node memory, one read and one write port.
  node_t                 nmem [MAX_NODES];
  node_t                 nrd_q;
  logic [NODE_BITS-1:0]  nraddr;
  logic                  nwe;
  logic [NODE_BITS-1:0]  nwaddr;
  node_t                 nwdata;

  // Edge store.
  logic                  ewe;
  logic [STORE_BITS-1:0] ewaddr;
  edge_t                 ewdata;
  edge_t                 erd;

  logic                  accept;
  logic                  cand;
  logic [DIST_BITS-1:0]  sel_best;
  logic [NODE_BITS-1:0]  sel_pick;
  logic [DIST_BITS:0]    sum_wide;
  logic [DIST_BITS-1:0]  sum_sat;

  ssp_edge_ram u_edges (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (ewaddr),
    .wdata_i (ewdata),
    .raddr_i (eidx_q[STORE_BITS-1:0]),
    .rdata_o (erd)
  );

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      nmem[nwaddr] <= nwdata;
    end
    nrd_q <= nmem[nraddr];
  end

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // The node read in the cycle before wins if it is unvisited and strictly smaller;
  // the scan runs upward, so ties keep the lowest index.
  assign cand     = sv_q && !nrd_q.vis && (nrd_q.path_len < best_q);
  assign sel_best = cand ? nrd_q.path_len : best_q;
  assign sel_pick = cand ? chk_idx_q : pick_q;

  // Relaxed distance, capped at infinity.
  assign sum_wide = {1'b0, best_q} + {{(DIST_BITS+1-WEIGHT_BITS){1'b0}}, erd.weight};
  assign sum_sat  = (sum_wide > {1'b0, INF_DIST}) ? INF_DIST : sum_wide[DIST_BITS-1:0];

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    n_d     = n_q;
    idx_d   = idx_q;
    sv_d    = 1'b0;
    best_d  = best_q;
    pick_d  = pick_q;
    eidx_d  = eidx_q;
    qok_d   = qok_q;
    qa_d    = qa_q;
    nraddr  = idx_q;
    nwe     = 1'b0;
    nwaddr  = idx_q;
    nwdata  = '{vis: 1'b0, path_len: INF_DIST};
    ewe     = 1'b0;
    ewaddr  = total_q[STORE_BITS-1:0];
    ewdata  = '{from_node: end_a_i, to_node: end_b_i, weight: weight_i};

    case (state_q)
      S_IDLE: begin
        nraddr = end_a_i;
        if (accept) begin
          case (op_i)
            OP_ADD: begin
              if (total_q > TOTAL_BITS'(STORE_DEPTH - 2)) begin
                ovf_d = 1'b1;
              end else begin
                ewe     = 1'b1;
                state_d = S_ADD2;
              end
            end
            OP_RUN: begin
              n_d     = (ncfg_q == '0) ? NODE_BITS'(1) : ncfg_q;
              idx_d   = NODE_BITS'(1);
              state_d = S_INIT;
            end
            OP_QUERY: begin
              qa_d    = end_a_i;
              qok_d   = (end_a_i != '0) && (end_a_i <= ncfg_q);
              state_d = S_QRY;
            end
            OP_CLEAR: begin
              total_d = '0;
              ovf_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_ADD2: begin
        ewe     = 1'b1;
        ewaddr  = total_q[STORE_BITS-1:0] + STORE_BITS'(1);
        ewdata  = '{from_node: hold_b_q, to_node: hold_a_q, weight: hold_w_q};
        total_d = total_q + TOTAL_BITS'(2);
        state_d = S_IDLE;
      end
      S_QRY: begin
        state_d = S_IDLE;
      end
      S_INIT: begin
        nwe    = 1'b1;
        nwdata = '{vis: 1'b0, path_len: (idx_q == NODE_BITS'(1)) ? '0 : INF_DIST};
        if (idx_q == n_q) begin
          idx_d   = NODE_BITS'(1);
          best_d  = INF_DIST;
          pick_d  = '0;
          state_d = S_SEL;
        end else begin
          idx_d = idx_q + NODE_BITS'(1);
        end
      end
      S_SEL: begin
        sv_d   = 1'b1;
        best_d = sel_best;
        pick_d = sel_pick;
        if (idx_q == n_q) begin
          state_d = S_SELW;
        end else begin
          idx_d = idx_q + NODE_BITS'(1);
        end
      end
      S_SELW: begin
        best_d = sel_best;
        pick_d = sel_pick;
        if (sel_pick == '0) begin
          state_d = S_IDLE;
        end else begin
          nwe     = 1'b1;
          nwaddr  = sel_pick;
          nwdata  = '{vis: 1'b1, path_len: sel_best};
          eidx_d  = '0;
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        if (eidx_q == total_q) begin
          idx_d   = NODE_BITS'(1);
          best_d  = INF_DIST;
          pick_d  = '0;
          state_d = S_SEL;
        end else begin
          state_d = S_ECHK;
        end
      end
      S_ECHK: begin
        nraddr = erd.to_node;
        if ((erd.from_node == pick_q) && (erd.to_node != '0) && (erd.to_node <= n_q)) begin
          state_d = S_EUPD;
        end else begin
          eidx_d  = eidx_q + TOTAL_BITS'(1);
          state_d = S_ERD;
        end
      end
      S_EUPD: begin
        nwaddr = erd.to_node;
        nwdata = '{vis: nrd_q.vis, path_len: sum_sat};
        nwe    = (sum_sat < nrd_q.path_len);
        eidx_d  = eidx_q + TOTAL_BITS'(1);
        state_d = S_ERD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      ovf_q   <= 1'b0;
      ncfg_q  <= NODE_BITS'(1);
      sv_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      sv_q    <= sv_d;
      res_v_q <= (state_q == S_QRY);
      if (cfg_valid_i && cfg_ready_o) begin
        ncfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    idx_q     <= idx_d;
    chk_idx_q <= idx_q;
    best_q    <= best_d;
    pick_q    <= pick_d;
    eidx_q    <= eidx_d;
    qok_q     <= qok_d;
    qa_q      <= qa_d;
    if (accept) begin
      hold_a_q <= end_a_i;
      hold_b_q <= end_b_i;
      hold_w_q <= weight_i;
    end
    if (state_q == S_QRY) begin
      res_idx_q  <= qa_q;
      res_dist_q <= qok_q ? nrd_q.path_len : INF_DIST;
    end
  end

  assign result_valid_o = res_v_q;
  assign node_index_o   = res_idx_q;
  assign distance_o     = res_dist_q;
  assign overflow_o     = ovf_q;

  // A result only follows a query read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_QRY))
    else $error("result without query");

  // The edge store never holds more than its depth, always in pairs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q <= TOTAL_BITS'(STORE_DEPTH)) && !total_q[0])
    else $error("edge count out of range");

  // Relaxation only happens for a selected node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EUPD) |-> (pick_q != '0))
    else $error("relax without selected node");

  // An add that is taken always writes its second direction next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD2) |=> (state_q == S_IDLE) && (total_q == $past(total_q) + TOTAL_BITS'(2)))
    else $error("edge pair not completed");

endmodule

FILE: tb/single_source_shortest_path_core_tb.sv
module single_source_shortest_path_core_tb;
  import ssp_pkg::*;

  // Clock, reset and the ports of the block.
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             op_i = OP_ADD;
  logic [NODE_BITS-1:0]   end_a_i = '0;
  logic [NODE_BITS-1:0]   end_b_i = '0;
  logic [WEIGHT_BITS-1:0] weight_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [NODE_BITS-1:0]   cfg_data_i = '0;
  logic                   result_valid_o;
  logic [NODE_BITS-1:0]   node_index_o;
  logic [DIST_BITS-1:0]   distance_o;
  logic                   overflow_o;

  single_source_shortest_path_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .end_a_i        (end_a_i),
    .end_b_i        (end_b_i),
    .weight_i       (weight_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .node_index_o   (node_index_o),
    .distance_o     (distance_o),
    .overflow_o     (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  // One expected query answer.
  typedef struct packed {
    logic [NODE_BITS-1:0] node;
    logic [DIST_BITS-1:0] path_len;
    logic                 ovf;
  } answer_t;

  answer_t pending_answers[$];

  // Shadow copy of the graph and of the distance table.
  logic [NODE_BITS-1:0]   sh_from [STORE_DEPTH];
  logic [NODE_BITS-1:0]   sh_to   [STORE_DEPTH];
  logic [WEIGHT_BITS-1:0] sh_w    [STORE_DEPTH];
  int unsigned            sh_total;
  logic [DIST_BITS-1:0]   sh_dist [MAX_NODES];
  bit                     sh_seen [MAX_NODES];
  bit                     sh_ovf;
  int unsigned            sh_count;
  // Highest node whose distance entry a run has ever written. Queries never read
  // above it, since those entries hold no defined value.
  int unsigned            written_hi;

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned answers_seen = 0;
  int unsigned runs_done = 0;
  int unsigned stall_cycles = 0;
  bit          burst = 1'b0;

  // The node count that a run really uses: at least one, at most MAX_NODES-1.
  function automatic int unsigned active_nodes();
    int unsigned n;
    n = sh_count;
    if (n < 1) n = 1;
    if (n > MAX_NODES - 1) n = MAX_NODES - 1;
    return n;
  endfunction

  // Dijkstra's method from node 1 over the shadow store.
  function automatic void solve_paths();
    int unsigned n;
    int unsigned pick;
    int unsigned e;
    logic [DIST_BITS-1:0] pd;
    longint unsigned sum;
    n = active_nodes();
    for (int unsigned i = 1; i <= n; i++) begin
      sh_dist[i] = INF_DIST;
      sh_seen[i] = 1'b0;
    end
    sh_dist[1] = '0;
    if (n > written_hi) written_hi = n;
    forever begin
      pick = 0;
      pd = INF_DIST;
      // Lowest index wins a tie, since only a strictly smaller distance replaces.
      for (int unsigned i = 1; i <= n; i++) begin
        if (!sh_seen[i] && sh_dist[i] < pd) begin
          pd = sh_dist[i];
          pick = i;
        end
      end
      if (pick == 0) break;
      sh_seen[pick] = 1'b1;
      for (e = 0; e < sh_total; e++) begin
        if (sh_from[e] != pick) continue;
        if (sh_to[e] == 0 || sh_to[e] > n) continue;
        sum = 64'(pd) + 64'(sh_w[e]);
        if (sum > INF_DIST) sum = INF_DIST;
        if (sum < sh_dist[sh_to[e]]) sh_dist[sh_to[e]] = sum[DIST_BITS-1:0];
      end
    end
  endfunction

  // Applies one accepted item to the shadow state; queries leave an answer behind.
  function automatic void apply_item(logic [1:0] op, logic [NODE_BITS-1:0] a,
                                     logic [NODE_BITS-1:0] b, logic [WEIGHT_BITS-1:0] w);
    answer_t ans;
    case (op)
      OP_ADD: begin
        // A full store drops the whole edge and raises the sticky overflow.
        if (sh_total + 2 > STORE_DEPTH) begin
          sh_ovf = 1'b1;
        end else begin
          sh_from[sh_total] = a;
          sh_to[sh_total] = b;
          sh_w[sh_total] = w;
          sh_from[sh_total+1] = b;
          sh_to[sh_total+1] = a;
          sh_w[sh_total+1] = w;
          sh_total += 2;
        end
      end
      OP_RUN: begin
        solve_paths();
        runs_done++;
      end
      OP_CLEAR: begin
        sh_total = 0;
        sh_ovf = 1'b0;
      end
      default: begin
        ans.node = a;
        ans.path_len = INF_DIST;
        if (a >= 1 && a <= active_nodes() && a <= sh_count) ans.path_len = sh_dist[a];
        ans.ovf = sh_ovf;
        pending_answers = {pending_answers, ans};
      end
    endcase
  endfunction

  // Presents one item after a random pause (none in burst mode) and waits until the block takes it.
  task automatic issue_item(logic [1:0] op, logic [NODE_BITS-1:0] a,
                            logic [NODE_BITS-1:0] b, logic [WEIGHT_BITS-1:0] w);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    end_a_i <= a;
    end_b_i <= b;
    weight_i <= w;
    do @(posedge clk_i); while (busy);
    apply_item(op, a, b, w);
    items_sent++;
  endtask

  // Waits until every answer is in and the block has gone idle, then writes the
  // node count register.
  task automatic set_node_count(logic [NODE_BITS-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    // A run or an add gives no answer, so the block may still be working.
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sh_count = 32'(value);
  endtask

  // Checks every strobed answer against the oldest one still pending.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && result_valid_o) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer node %0d distance %0d overflow %0d",
                 $time, node_index_o, distance_o, overflow_o);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (node_index_o !== want.node) begin
          $display("%0t: node_index expected %0d actual %0d", $time, want.node, node_index_o);
          errors++;
        end
        if (distance_o !== want.path_len) begin
          $display("%0t: distance of node %0d expected %0d actual %0d",
                   $time, want.node, want.path_len, distance_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: a run at the full node count shows no activity on the watched signals until
  // it ends, so the limit must exceed the length of such a run.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 4000000) begin
        $display("%0t: watchdog expired", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Directed stimulus. A row either writes the node count or sends an item;
  // rows with check set also carry the answer read straight off the rules.
  typedef struct {
    bit                     is_cfg;
    logic [1:0]             op;
    logic [NODE_BITS-1:0]   a;
    logic [NODE_BITS-1:0]   b;
    logic [WEIGHT_BITS-1:0] w;
    bit                     check;
    logic [DIST_BITS-1:0]   path_len;
    logic                   ovf;
  } step_row_t;

  step_row_t directed_rows[] = '{
    // Right after reset the node count is one: only node 1 exists.
    '{0, OP_RUN,   10'd0,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd1,    10'd0,    16'd0,     1, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd0,    10'd0,    16'd0,     1, INF_DIST, 1'b0},
    '{0, OP_QUERY, 10'd1023, 10'd0,    16'd0,     1, INF_DIST, 1'b0},
    '{1, OP_ADD,   10'd5,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd1,    10'd2,    16'd65535, 0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd2,    10'd3,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd3,    10'd3,    16'd7,     0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd0,    10'd4,    16'd1,     0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd4,    10'd1023, 16'd9,     0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd1,    10'd5,    16'd3,     0, 30'd0,  1'b0},
    '{0, OP_ADD,   10'd5,    10'd3,    16'd2,     0, 30'd0,  1'b0},
    '{0, OP_RUN,   10'd0,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd1,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd2,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd3,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd4,    10'd0,    16'd0,     1, INF_DIST, 1'b0},
    '{0, OP_QUERY, 10'd5,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd6,    10'd0,    16'd0,     1, INF_DIST, 1'b0},
    '{0, OP_CLEAR, 10'd0,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    // A node count of zero still runs node 1, but every query reads infinity.
    '{1, OP_ADD,   10'd0,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_RUN,   10'd0,    10'd0,    16'd0,     0, 30'd0,  1'b0},
    '{0, OP_QUERY, 10'd1,    10'd0,    16'd0,     1, INF_DIST, 1'b0}
  };

  initial begin
    int unsigned n;
    int unsigned edges;
    int unsigned queries;
    logic [NODE_BITS-1:0] a;
    logic [NODE_BITS-1:0] b;
    logic [WEIGHT_BITS-1:0] w;

    sh_total = 0;
    sh_ovf = 1'b0;
    sh_count = 1;
    written_hi = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        set_node_count(directed_rows[i].a);
      end else begin
        issue_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].w);
        // The typed-in answer must agree with what the shadow model just queued.
        if (directed_rows[i].check && pending_answers.size() != 0) begin
          if (pending_answers[$].path_len !== directed_rows[i].path_len ||
              pending_answers[$].ovf !== directed_rows[i].ovf) begin
            $display("%0t: table row %0d expected distance %0d overflow %0d, shadow %0d %0d",
                     $time, i, directed_rows[i].path_len, directed_rows[i].ovf,
                     pending_answers[$].path_len, pending_answers[$].ovf);
            errors++;
          end
        end
      end
    end

    // Full node count: one run with a tiny graph, then the far end of the range.
    set_node_count(10'd1023);
    issue_item(OP_CLEAR, '0, '0, '0);
    issue_item(OP_ADD, 10'd1, 10'd1023, 16'd40000);
    issue_item(OP_ADD, 10'd1023, 10'd512, 16'd65535);
    issue_item(OP_RUN, '0, '0, '0);
    issue_item(OP_QUERY, 10'd1023, '0, '0);
    issue_item(OP_QUERY, 10'd512, '0, '0);
    issue_item(OP_QUERY, 10'd700, '0, '0);

    // Back-to-back adds with stray endpoints over a small node count.
    set_node_count(10'd4);
    issue_item(OP_CLEAR, '0, '0, '0);
    issue_item(OP_ADD, 10'd1, 10'd2, 16'd5);
    issue_item(OP_RUN, '0, '0, '0);
    burst = 1'b1;
    for (int unsigned k = 0; k < 40; k++) begin
      issue_item(OP_ADD, NODE_BITS'($urandom_range(0, 1023)),
                 NODE_BITS'($urandom_range(0, 1023)), WEIGHT_BITS'($urandom()));
    end
    burst = 1'b0;
    issue_item(OP_QUERY, 10'd2, '0, '0);
    issue_item(OP_RUN, '0, '0, '0);
    issue_item(OP_QUERY, 10'd2, '0, '0);
    issue_item(OP_QUERY, 10'd3, '0, '0);
    issue_item(OP_CLEAR, '0, '0, '0);
    issue_item(OP_QUERY, 10'd2, '0, '0);

    // The sender holds off here until every answer so far has come back.
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);

    // Random sessions: set a node count, build a graph, run it, ask about it.
    while (items_sent < 1950) begin
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(2, 12);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1);
      set_node_count(NODE_BITS'(n));
      if ($urandom_range(0, 4) != 0) issue_item(OP_CLEAR, '0, '0, '0);
      edges = $urandom_range(0, 2 * n + 4);
      for (int unsigned k = 0; k < edges; k++) begin
        a = NODE_BITS'($urandom_range(1, n + 1));
        b = NODE_BITS'($urandom_range(1, n + 1));
        case ($urandom_range(0, 9))
          0: a = NODE_BITS'($urandom_range(0, 1023));
          1: b = NODE_BITS'($urandom_range(0, 1023));
          2: b = a;
          default: ;
        endcase
        w = ($urandom_range(0, 3) == 0) ? WEIGHT_BITS'($urandom()) :
                                          WEIGHT_BITS'($urandom_range(0, 50));
        issue_item(OP_ADD, a, b, w);
      end
      // Now and then a stray query lands before the run.
      if ($urandom_range(0, 5) == 0 && written_hi > 0) begin
        issue_item(OP_QUERY, NODE_BITS'($urandom_range(0, written_hi)), '0, '0);
      end
      issue_item(OP_RUN, '0, '0, '0);
      queries = $urandom_range(n + 1, n + 12);
      for (int unsigned k = 0; k < queries; k++) begin
        a = ($urandom_range(0, 7) == 0) ? NODE_BITS'($urandom_range(0, 1023)) :
                                          NODE_BITS'($urandom_range(0, n + 1));
        // Never read a distance entry that no run has written.
        if (a >= 1 && a <= active_nodes() && a <= sh_count && a > written_hi) begin
          a = NODE_BITS'(1);
        end
        issue_item(OP_QUERY, a, '0, '0);
      end
      if ($urandom_range(0, 3) == 0) issue_item($urandom_range(0, 1) ? OP_ADD : OP_CLEAR,
                                                NODE_BITS'($urandom_range(0, 1023)),
                                                NODE_BITS'($urandom_range(0, 1023)),
                                                WEIGHT_BITS'($urandom()));
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items with %0d runs; checked %0d distance answers.",
             items_sent, runs_done, answers_seen);
    $display("Node counts from 0 to 1023, edge bursts, self loops and stray endpoints.");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
